>>> hw/rtl/u8dec_pkg.sv
// Package of the UTF-8 stream decoder: byte classes, the command passed from
// the front to the back and the result layout. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned LenWidth = 3;

  typedef enum logic [2:0] {
    KIND_TERM,
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_INVALID
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic        cont_ok;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [CpWidth-1:0]  codepoint;
    logic                has_codepoint;
    logic                malformed;
    logic                end_of_string;
    logic [LenWidth-1:0] seq_length;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/u8dec_fifo.sv
// Small register queue used between the decoder stages and at the output.
// Depends on nothing; the entry width is a parameter.
`timescale 1ns / 1ps
`default_nettype none

module u8dec_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/u8dec_front.sv
// Front stage of the UTF-8 decoder: classifies each incoming byte into a
// command for the back stage. Depends on u8dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8dec_front (
  input  wire logic [7:0]  data_byte_i,
  output u8dec_pkg::cmd_t  cmd_o
);

  import u8dec_pkg::*;

  always_comb begin
    cmd_o.data    = data_byte_i;
    cmd_o.cont_ok = (data_byte_i[7:6] == 2'b10);
    priority if (data_byte_i == 8'h00) begin
      cmd_o.kind = KIND_TERM;
    end else if (data_byte_i[7] == 1'b0) begin
      cmd_o.kind = KIND_ASCII;
    end else if (data_byte_i[7:5] == 3'b110) begin
      cmd_o.kind = KIND_LEAD2;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      cmd_o.kind = KIND_LEAD3;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      cmd_o.kind = KIND_LEAD4;
    end else begin
      cmd_o.kind = KIND_INVALID;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/u8dec_back.sv
// Back stage of the UTF-8 decoder: holds the sequence state, gathers payload
// bits and forms one result per finished sequence or zero byte. Depends on u8dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8dec_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire u8dec_pkg::cmd_t  cmd_i,
  output logic                  cmd_take_o,
  input  wire logic             res_full_i,
  output logic                  res_push_o,
  output u8dec_pkg::res_t       res_o
);

  import u8dec_pkg::*;

  logic [CpWidth-1:0]  acc_q, acc_d;
  logic [1:0]          rem_q, rem_d;
  logic [LenWidth-1:0] total_q, total_d;
  logic                bad_q, bad_d;
  logic                emit;
  logic [CpWidth-1:0]  cont_acc;
  logic [CpWidth-1:0]  trunc_cp;

  assign cmd_take_o = cmd_valid_i && !res_full_i;
  assign res_push_o = cmd_take_o && emit;
  assign cont_acc   = {acc_q[CpWidth-7:0], cmd_i.data[5:0]};

  always_comb begin
    unique case (rem_q)
      2'd1:    trunc_cp = {acc_q[CpWidth-7:0], 6'd0};
      2'd2:    trunc_cp = {acc_q[CpWidth-13:0], 12'd0};
      2'd3:    trunc_cp = {acc_q[CpWidth-19:0], 18'd0};
      default: trunc_cp = acc_q;
    endcase
  end

  always_comb begin
    acc_d   = acc_q;
    rem_d   = rem_q;
    total_d = total_q;
    bad_d   = bad_q;
    emit    = 1'b0;
    res_o   = '0;
    priority if (cmd_i.kind == KIND_TERM) begin
      emit                = 1'b1;
      res_o.end_of_string = 1'b1;
      if (rem_q != 2'd0) begin
        res_o.codepoint     = trunc_cp;
        res_o.has_codepoint = 1'b1;
        res_o.malformed     = 1'b1;
        res_o.seq_length    = total_q - LenWidth'(rem_q);
      end
      acc_d   = '0;
      rem_d   = '0;
      total_d = '0;
      bad_d   = 1'b0;
    end else if (rem_q != 2'd0) begin
      acc_d = cont_acc;
      rem_d = rem_q - 2'd1;
      bad_d = bad_q | !cmd_i.cont_ok;
      if (rem_q == 2'd1) begin
        emit                = 1'b1;
        res_o.codepoint     = cont_acc;
        res_o.has_codepoint = 1'b1;
        res_o.malformed     = bad_q | !cmd_i.cont_ok;
        res_o.seq_length    = total_q;
        acc_d   = '0;
        total_d = '0;
        bad_d   = 1'b0;
      end
    end else begin
      unique case (cmd_i.kind)
        KIND_ASCII: begin
          emit                = 1'b1;
          res_o.codepoint     = CpWidth'(cmd_i.data[6:0]);
          res_o.has_codepoint = 1'b1;
          res_o.seq_length    = LenWidth'(1);
        end
        KIND_LEAD2: begin
          acc_d   = CpWidth'(cmd_i.data[4:0]);
          rem_d   = 2'd1;
          total_d = LenWidth'(2);
          bad_d   = 1'b0;
        end
        KIND_LEAD3: begin
          acc_d   = CpWidth'(cmd_i.data[3:0]);
          rem_d   = 2'd2;
          total_d = LenWidth'(3);
          bad_d   = 1'b0;
        end
        KIND_LEAD4: begin
          acc_d   = CpWidth'(cmd_i.data[2:0]);
          rem_d   = 2'd3;
          total_d = LenWidth'(4);
          bad_d   = 1'b0;
        end
        default: begin
          emit                = 1'b1;
          res_o.has_codepoint = 1'b1;
          res_o.malformed     = 1'b1;
          res_o.seq_length    = LenWidth'(1);
          acc_d   = '0;
          total_d = '0;
          bad_d   = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      rem_q   <= '0;
      total_q <= '0;
      bad_q   <= 1'b0;
    end else if (cmd_take_o) begin
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      total_q <= total_d;
      bad_q   <= bad_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/utf8_stream_decoder_core.sv
// Top level of the UTF-8 stream decoder: front classifier, command queue,
// back decoder and result queue. Depends on u8dec_pkg and all u8dec modules.
//
// Usage: bytes of a NUL-terminated UTF-8 string enter through push/full; a
// transaction takes place at a rising edge with push high and full low.
// Results leave through empty/pop: the oldest result sits on the result ports
// while empty is low and is taken at an edge with pop high and empty low.
// A byte gives zero or one result; a zero byte always gives one, flagged
// end_of_string, and clears any pending sequence.
// A taken byte is registered in the command queue; its result, if any, is
// registered in the result queue. Throughput: one byte per cycle while the
// result queue has room; the back stage updates the state for each command.
// When the receiver stalls, results collect in the result queue (ResDepth
// entries); once it is full the back stage holds, the command queue
// (CmdDepth entries) fills and full rises. Reset empties both queues and
// clears the sequence state.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_core #(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned ResDepth = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    data_byte_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [u8dec_pkg::CpWidth-1:0]      codepoint_o,
  output logic                               has_codepoint_o,
  output logic                               malformed_o,
  output logic                               end_of_string_o,
  output logic [u8dec_pkg::LenWidth-1:0]     seq_length_o
);

  import u8dec_pkg::*;

  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;
  logic cmd_empty, cmd_take;
  logic res_full, res_push;

  u8dec_front u_front (
    .data_byte_i (data_byte_i),
    .cmd_o       (cmd_in)
  );

  u8dec_fifo #(
    .Depth (CmdDepth),
    .Width ($bits(cmd_t))
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_take),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  u8dec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_take_o  (cmd_take),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  u8dec_fifo #(
    .Depth (ResDepth),
    .Width ($bits(res_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign codepoint_o     = res_out.codepoint;
  assign has_codepoint_o = res_out.has_codepoint;
  assign malformed_o     = res_out.malformed;
  assign end_of_string_o = res_out.end_of_string;
  assign seq_length_o    = res_out.seq_length;

endmodule

`default_nettype wire
